/* hdl/cka_pkg.sv */
// Package for the chroma key alpha unit: widths, register and mode codes,
// pipeline stage map and the per-step functions of the square root and divider.
// No dependencies.
package cka_pkg;

   localparam int PIX_W    = 8;
   localparam int TOL_W    = 12;
   localparam int SQ_W     = 17;
   localparam int SQV_W    = 18;
   localparam int ROOT_W   = 9;
   localparam int REM_W    = 11;
   localparam int D10_W    = 12;
   localparam int NUM_W    = 20;
   localparam int QUO_W    = 8;
   localparam int CSR_IDX_W = 3;

   localparam int SQRT_STAGES = 3;
   localparam int SQRT_STEPS  = 3;
   localparam int DIV_STAGES  = 4;
   localparam int DIV_STEPS   = 2;

   // pipeline stage map
   localparam int ST_ABS   = 0;
   localparam int ST_SQR   = 1;
   localparam int ST_ROOT  = 2;
   localparam int ST_D10   = ST_ROOT + SQRT_STAGES;
   localparam int ST_CLS   = ST_D10 + 1;
   localparam int ST_NUM   = ST_CLS + 1;
   localparam int ST_DIV   = ST_NUM + 1;
   localparam int ST_OUT   = ST_DIV + DIV_STAGES;
   localparam int PIPE_DEPTH = ST_OUT + 1;
   localparam int CLS_LEN  = DIV_STAGES + 2;

   localparam logic [ROOT_W-1:0] ROOT_MAX = ROOT_W'(360);
   localparam logic [D10_W-1:0]  D10_MAX  = D10_W'(3600);
   localparam logic [PIX_W-1:0]  ALPHA_FULL = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TOL_NEAR   = 3'd0,
      CSR_TOL_FAR    = 3'd1,
      CSR_KEY_CB     = 3'd2,
      CSR_KEY_CR     = 3'd3,
      CSR_MERGE_MODE = 3'd4
   } csr_idx_type;

   typedef enum logic [1:0] {
      MERGE_REPLACE = 2'd0,
      MERGE_FILL    = 2'd1,
      MERGE_AVG     = 2'd2,
      MERGE_ADD     = 2'd3
   } merge_type;

   typedef enum logic [1:0] {
      KEY_ZERO = 2'd0,
      KEY_RAMP = 2'd1,
      KEY_FULL = 2'd2
   } key_cls_type;

   typedef struct packed {
      logic [SQV_W-1:0]  val;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_type;

   typedef struct packed {
      logic [NUM_W-1:0] rem;
      logic [QUO_W-1:0] quo;
   } div_type;

   // one digit of the digit-by-digit integer square root
   function automatic sqrt_type sqrt_step(sqrt_type s);
      logic [REM_W+1:0] r2;
      logic [REM_W+1:0] trial;
      sqrt_type         n;
      r2    = {s.rem, s.val[SQV_W-1 -: 2]};
      trial = {{(REM_W-ROOT_W){1'b0}}, s.root, 2'b01};
      n.val = {s.val[SQV_W-3:0], 2'b00};
      if (r2 >= trial) begin
         n.rem  = REM_W'(r2 - trial);
         n.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
         n.rem  = REM_W'(r2);
         n.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      return n;
   endfunction

   // one quotient bit of a restoring divide
   function automatic div_type div_step(div_type s, logic [TOL_W-1:0] den,
                                        logic [2:0] pos);
      logic [NUM_W-1:0] sub;
      div_type          n;
      sub = {{(NUM_W-TOL_W){1'b0}}, den} << pos;
      n   = s;
      if (s.rem >= sub) begin
         n.rem      = s.rem - sub;
         n.quo[pos] = 1'b1;
      end
      return n;
   endfunction

endpackage

/* hdl/chroma_key_alpha_unit.sv */
// Soft chroma key on the Cb/Cr plane with alpha merge, fully pipelined.
// Depends on cka_pkg (hdl/cka_pkg.sv).
//
// Usage:
//   req channel: one pixel per transfer, req_tdata = {alpha_in, pix_cr, pix_cb}.
//   rsp channel: one alpha per pixel, rsp_tdata = alpha_out, in input order.
//   csr channel: register writes (index 0 tol_near, 1 tol_far, 2 key_cb,
//     3 key_cr, 4 merge_mode), always ready; write only while the pipe is empty.
// One pixel per cycle sustained while no rsp stall holds the pipe. The depth is set
// by the square root (9 digits over 3 stages) and the ramp divider (8 quotient
// bits over 4 stages).
// A rsp stall freezes every stage; req_tready drops in the same cycle, so no
// pixel is dropped or repeated and the pipe resumes where it stopped.
// Reset clears all valid bits and loads the register defaults (near 15,
// far 15, key 128/128, replace mode).
module chroma_key_alpha_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [23:0]               req_tdata,  // pix_cb[7:0], pix_cr[15:8], alpha_in[23:16]
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [7:0]                rsp_tdata,  // alpha_out[7:0]
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  cka_pkg::csr_idx_type      csr_index,
   input  logic [cka_pkg::TOL_W-1:0] csr_data
);
   import cka_pkg::*;

   // configuration
   logic [TOL_W-1:0] tol_near_ff, tol_far_ff;
   logic [PIX_W-1:0] key_cb_ff, key_cr_ff;
   merge_type        merge_mode_ff;
   logic [TOL_W-1:0] den;

   // pipeline
   logic                adv;
   logic [PIPE_DEPTH-1:0] vld_ff, vld_in;
   logic [PIX_W-1:0]    alpha_ff [ST_OUT];
   logic [PIX_W-1:0]    dx_ff, dy_ff, dx_in, dy_in;
   logic [SQ_W-1:0]     sq_ff, sq_in;
   sqrt_type            rt_ff [SQRT_STAGES];
   sqrt_type            rt_in [SQRT_STAGES];
   logic [D10_W-1:0]    d10_ff, d10_in;
   key_cls_type         cls_ff [CLS_LEN];
   key_cls_type         cls_in;
   logic [TOL_W-1:0]    diff_ff, diff_in;
   div_type             dv_ff [DIV_STAGES+1];
   div_type             dv_in [DIV_STAGES+1];
   logic [PIX_W-1:0]    alpha_out_ff, alpha_out_in;

   assign csr_ready  = 1'b1;
   assign adv        = !vld_ff[ST_OUT] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[ST_OUT];
   assign rsp_tdata  = alpha_out_ff;
   assign den        = tol_far_ff - tol_near_ff;
   assign vld_in     = {vld_ff[PIPE_DEPTH-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_near_ff   <= TOL_W'(15);
         tol_far_ff    <= TOL_W'(15);
         key_cb_ff     <= PIX_W'(128);
         key_cr_ff     <= PIX_W'(128);
         merge_mode_ff <= MERGE_REPLACE;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TOL_NEAR:   tol_near_ff   <= csr_data;
            CSR_TOL_FAR:    tol_far_ff    <= csr_data;
            CSR_KEY_CB:     key_cb_ff     <= csr_data[PIX_W-1:0];
            CSR_KEY_CR:     key_cr_ff     <= csr_data[PIX_W-1:0];
            CSR_MERGE_MODE: merge_mode_ff <= merge_type'(csr_data[1:0]);
            default: ;
         endcase
      end
   end

   // stage 0: absolute chroma differences
   always_comb begin
      dx_in = (key_cb_ff > req_tdata[7:0]) ? key_cb_ff - req_tdata[7:0]
                                           : req_tdata[7:0] - key_cb_ff;
      dy_in = (key_cr_ff > req_tdata[15:8]) ? key_cr_ff - req_tdata[15:8]
                                            : req_tdata[15:8] - key_cr_ff;
   end

   // stage 1: squared distance
   assign sq_in = SQ_W'({8'd0, dx_ff} * {8'd0, dx_ff}) + SQ_W'({8'd0, dy_ff} * {8'd0, dy_ff});

   // stages 2..4: square root, three digits per stage
   always_comb begin
      sqrt_type s;
      for (int k = 0; k < SQRT_STAGES; k++) begin
         if (k == 0) begin
            s.val  = {1'b0, sq_ff};
            s.rem  = '0;
            s.root = '0;
         end else begin
            s = rt_ff[k-1];
         end
         for (int j = 0; j < SQRT_STEPS; j++) begin
            s = sqrt_step(s);
         end
         rt_in[k] = s;
      end
   end

   // stage 5: distance in tenths
   assign d10_in = D10_W'({rt_ff[SQRT_STAGES-1].root, 3'b000})
                 + D10_W'({rt_ff[SQRT_STAGES-1].root, 1'b0});

   // stage 6: classify against the tolerances
   always_comb begin
      diff_in = d10_ff - tol_near_ff;
      if (d10_ff < tol_near_ff) begin
         cls_in = KEY_ZERO;
      end else if (d10_ff < tol_far_ff) begin
         cls_in = KEY_RAMP;
      end else begin
         cls_in = KEY_FULL;
      end
   end

   // stage 7: numerator 255 * diff; stages 8..11: divide, two bits per stage
   always_comb begin
      div_type d;
      dv_in[0].rem = {diff_ff, 8'd0} - {8'd0, diff_ff};
      dv_in[0].quo = '0;
      for (int k = 0; k < DIV_STAGES; k++) begin
         d = dv_ff[k];
         for (int j = 0; j < DIV_STEPS; j++) begin
            d = div_step(d, den, 3'(QUO_W - 1 - (k * DIV_STEPS + j)));
         end
         dv_in[k+1] = d;
      end
   end

   // stage 12: key value and merge
   always_comb begin
      logic [PIX_W-1:0] key;
      logic [PIX_W:0]   sum;
      unique case (cls_ff[CLS_LEN-1])
         KEY_ZERO: key = '0;
         KEY_RAMP: key = dv_ff[DIV_STAGES].quo;
         default:  key = ALPHA_FULL;
      endcase
      sum = {1'b0, alpha_ff[ST_OUT-1]} + {1'b0, key};
      unique case (merge_mode_ff)
         MERGE_REPLACE: alpha_out_in = key;
         MERGE_FILL:    alpha_out_in = (alpha_ff[ST_OUT-1] == '0) ? key : alpha_ff[ST_OUT-1];
         MERGE_AVG:     alpha_out_in = sum[PIX_W:1];
         MERGE_ADD:     alpha_out_in = sum[PIX_W] ? ALPHA_FULL : sum[PIX_W-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         alpha_ff[0] <= req_tdata[23:16];
         for (int i = 1; i < ST_OUT; i++) begin
            alpha_ff[i] <= alpha_ff[i-1];
         end
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         sq_ff   <= sq_in;
         for (int k = 0; k < SQRT_STAGES; k++) begin
            rt_ff[k] <= rt_in[k];
         end
         d10_ff    <= d10_in;
         diff_ff   <= diff_in;
         cls_ff[0] <= cls_in;
         for (int i = 1; i < CLS_LEN; i++) begin
            cls_ff[i] <= cls_ff[i-1];
         end
         for (int k = 0; k <= DIV_STAGES; k++) begin
            dv_ff[k] <= dv_in[k];
         end
         alpha_out_ff <= alpha_out_in;
      end
   end

   a_root_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_D10-1] |-> rt_ff[SQRT_STAGES-1].root <= ROOT_MAX)
      else $error("chroma distance root out of range");

   a_d10_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_D10] |-> d10_ff <= D10_MAX)
      else $error("distance in tenths out of range");

   a_ramp_quo: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[ST_OUT-1] && cls_ff[CLS_LEN-1] == KEY_RAMP)
         |-> dv_ff[DIV_STAGES].quo != ALPHA_FULL)
      else $error("ramp quotient reached full alpha");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved during output stall");

endmodule

/* dv/chroma_key_alpha_unit_test.sv */
// Self-checking testbench for chroma_key_alpha_unit: pixels stream in, one alpha per pixel
// is checked against an in-bench model of the chroma distance key and the alpha merge.
// Depends on cka_pkg (hdl/cka_pkg.sv) and hdl/chroma_key_alpha_unit.sv.
module chroma_key_alpha_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import cka_pkg::*;

   typedef struct packed {
      logic [PIX_W-1:0] alpha_in;
      logic [PIX_W-1:0] pix_cr;
      logic [PIX_W-1:0] pix_cb;
   } pixel_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [23:0]       req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [7:0]        rsp_tdata;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   csr_idx_type       csr_index = CSR_TOL_NEAR;
   logic [TOL_W-1:0]  csr_data = '0;

   // register copy used for prediction
   logic [TOL_W-1:0]  cfg_near = 15;
   logic [TOL_W-1:0]  cfg_far = 15;
   logic [PIX_W-1:0]  cfg_key_cb = 128;
   logic [PIX_W-1:0]  cfg_key_cr = 128;
   merge_type         cfg_mode = MERGE_REPLACE;

   pixel_type         pixel_queue[$];
   logic [PIX_W-1:0]  alpha_expected[$];
   pixel_type         cur_pixel;
   int unsigned       n_queued = 0;
   int unsigned       n_accepted = 0;
   int unsigned       n_results = 0;
   int unsigned       n_errors = 0;
   int unsigned       n_settings = 0;
   int unsigned       send_wait = 0;
   int unsigned       recv_wait = 0;
   int unsigned       hold_left = 0;
   int unsigned       stall_orders = 0;
   int unsigned       stall_served = 0;
   bit                send_idle_on = 1'b0;
   bit                recv_idle_on = 1'b0;

   chroma_key_alpha_unit dut (.*);

   always #5 clock = ~clock;

   function automatic logic [PIX_W-1:0] predict_alpha(pixel_type px);
      int unsigned dx, dy, sq, root, d10, key_val, merged;
      dx = (px.pix_cb > cfg_key_cb) ? px.pix_cb - cfg_key_cb : cfg_key_cb - px.pix_cb;
      dy = (px.pix_cr > cfg_key_cr) ? px.pix_cr - cfg_key_cr : cfg_key_cr - px.pix_cr;
      sq = dx * dx + dy * dy;
      root = 0;
      for (int b = 8; b >= 0; b--) begin
         if ((root + (1 << b)) * (root + (1 << b)) <= sq)
            root += 1 << b;
      end
      d10 = root * 10;
      if (d10 < cfg_near)
         key_val = 0;
      else if (d10 < cfg_far)
         key_val = (255 * (d10 - cfg_near)) / (cfg_far - cfg_near);
      else
         key_val = 255;
      case (cfg_mode)
         MERGE_REPLACE: merged = key_val;
         MERGE_FILL:    merged = (px.alpha_in == 0) ? key_val : px.alpha_in;
         MERGE_AVG:     merged = (px.alpha_in + key_val) >> 1;
         default:       merged = (px.alpha_in + key_val > 255) ? 255 : px.alpha_in + key_val;
      endcase
      return merged[PIX_W-1:0];
   endfunction

   // pixel driver
   always @(posedge clock) begin
      logic offer;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_wait = 0;
      end else begin
         offer = req_tvalid;
         if (req_tvalid && req_tready) begin
            alpha_expected.push_back(predict_alpha(cur_pixel));
            n_accepted++;
            offer = 1'b0;
         end
         if (!offer) begin
            if (send_wait > 0)
               send_wait--;
            else if (pixel_queue.size() != 0) begin
               cur_pixel = pixel_queue.pop_front();
               req_tdata <= {cur_pixel.alpha_in, cur_pixel.pix_cr, cur_pixel.pix_cb};
               offer = 1'b1;
               send_wait = send_idle_on ? $urandom_range(0, 11) : 0;
            end
         end
         req_tvalid <= offer;
      end
   end

   // long back-pressure stretch, started on request
   always @(posedge clock) begin
      if (reset)
         hold_left <= 0;
      else if (stall_served != stall_orders) begin
         stall_served <= stall_orders;
         hold_left <= 250;
      end else if (hold_left > 0)
         hold_left <= hold_left - 1;
   end

   // alpha monitor
   always @(posedge clock) begin
      logic [PIX_W-1:0] want;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            n_results++;
            if (alpha_expected.size() == 0) begin
               $error("alpha_out: expected nothing, got %0d", rsp_tdata);
               n_errors++;
            end else begin
               want = alpha_expected.pop_front();
               if (rsp_tdata !== want) begin
                  $error("alpha_out: expected %0d, got %0d", want, rsp_tdata);
                  n_errors++;
               end
            end
            recv_wait = recv_idle_on ? $urandom_range(0, 11) : 0;
         end else if (recv_wait > 0)
            recv_wait--;
         rsp_tready <= (recv_wait == 0) && (hold_left == 0);
      end
   end

   task automatic write_reg(csr_idx_type idx, logic [TOL_W-1:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_TOL_NEAR:   cfg_near = val;
         CSR_TOL_FAR:    cfg_far = val;
         CSR_KEY_CB:     cfg_key_cb = val[PIX_W-1:0];
         CSR_KEY_CR:     cfg_key_cr = val[PIX_W-1:0];
         CSR_MERGE_MODE: cfg_mode = merge_type'(val[1:0]);
         default: ;
      endcase
   endtask

   // all five registers plus one write to an unused index
   task automatic set_regs(logic [TOL_W-1:0] near, logic [TOL_W-1:0] far,
                           logic [TOL_W-1:0] kcb, logic [TOL_W-1:0] kcr,
                           logic [TOL_W-1:0] mode);
      write_reg(CSR_TOL_NEAR, near);
      write_reg(CSR_TOL_FAR, far);
      write_reg(CSR_KEY_CB, kcb);
      write_reg(CSR_KEY_CR, kcr);
      write_reg(csr_idx_type'($urandom_range(CSR_MERGE_MODE + 1, (1 << CSR_IDX_W) - 1)),
                TOL_W'($urandom_range(0, (1 << TOL_W) - 1)));
      write_reg(CSR_MERGE_MODE, mode);
      csr_valid <= 1'b0;
      @(posedge clock);
      n_settings++;
   endtask

   task automatic push_pixel(int unsigned cb, int unsigned cr, int unsigned a);
      pixel_type px;
      px.pix_cb = cb[PIX_W-1:0];
      px.pix_cr = cr[PIX_W-1:0];
      px.alpha_in = a[PIX_W-1:0];
      pixel_queue.push_back(px);
      n_queued++;
   endtask

   task automatic push_random_pixel();
      int cb, cr;
      if ($urandom_range(0, 1)) begin
         cb = $urandom_range(0, 255);
         cr = $urandom_range(0, 255);
      end else begin
         // close to the key so the ramp gets hit
         cb = int'(cfg_key_cb) + int'($urandom_range(0, 60)) - 30;
         cr = int'(cfg_key_cr) + int'($urandom_range(0, 60)) - 30;
         cb = (cb < 0) ? 0 : (cb > 255) ? 255 : cb;
         cr = (cr < 0) ? 0 : (cr > 255) ? 255 : cr;
      end
      push_pixel(cb, cr, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 255));
   endtask

   task automatic random_settings();
      logic [TOL_W-1:0] near, far;
      case ($urandom_range(0, 7))
         0: begin near = 0; far = TOL_W'($urandom_range(0, (1 << TOL_W) - 1)); end
         1: begin
            near = TOL_W'($urandom_range(0, (1 << TOL_W) - 1));
            far = TOL_W'($urandom_range(0, near));
         end
         2: begin near = (1 << TOL_W) - 1; far = (1 << TOL_W) - 1; end
         3: begin near = 1; far = 2550; end
         default: begin
            near = TOL_W'($urandom_range(1, 1800));
            far = TOL_W'(near + $urandom_range(1, 750));
         end
      endcase
      set_regs(near, far, TOL_W'($urandom_range(0, 4095)), TOL_W'($urandom_range(0, 4095)),
               TOL_W'($urandom_range(0, 4095)));
   endtask

   // sender holds off until every expected alpha is back
   task automatic settle();
      while (n_accepted != n_queued || alpha_expected.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_regs(100, 1000, 128, 128, MERGE_REPLACE);
      push_pixel(128, 128, 0);
      push_pixel(0, 0, 255);
      push_pixel(138, 128, 0);
      push_pixel(228, 128, 0);
      push_pixel(200, 100, 0);
      push_pixel(255, 255, 255);
      push_pixel(0, 255, 0);
      push_pixel(255, 0, 255);
      settle();
      set_regs(0, 4095, 12'hF3C, 255, MERGE_FILL);
      push_pixel(60, 255, 0);
      push_pixel(0, 0, 255);
      push_pixel(255, 128, 1);
      settle();
      set_regs(4095, 0, 0, 0, MERGE_AVG);
      push_pixel(0, 0, 255);
      push_pixel(255, 255, 0);
      settle();
      set_regs(1, 2550, 255, 0, MERGE_ADD);
      push_pixel(255, 0, 0);
      push_pixel(0, 255, 255);
      push_pixel(100, 100, 200);
      settle();
      set_regs(0, 0, 128, 128, MERGE_REPLACE);
      push_pixel(128, 128, 77);
      settle();

      for (int ph = 0; ph < 9; ph++) begin
         random_settings();
         send_idle_on = (ph == 1) || (ph > 4 && $urandom_range(0, 1));
         recv_idle_on = (ph == 2) || (ph > 4 && $urandom_range(0, 1));
         if (ph == 3)
            stall_orders++;
         repeat (110) push_random_pixel();
         settle();
      end

      repeat (20) @(posedge clock);
      $display("Run covered %0d pixels and %0d alphas over %0d register settings",
               n_accepted, n_results, n_settings);
      $display("including empty ramps, zero and full tolerances and a long output stall");
      if (n_errors == 0 && alpha_expected.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d alphas outstanding", alpha_expected.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

/* files.f */
hdl/cka_pkg.sv
hdl/chroma_key_alpha_unit.sv
dv/chroma_key_alpha_unit_test.sv
